// File: design/rtbd_pkg.sv
// Shared widths, sizes, state encoding and control structs of the rtime block decompressor.
package rtbd_pkg;

	localparam int HIST_DEPTH     = 4096;
	localparam int HIST_AW        = $clog2(HIST_DEPTH);
	localparam int POS_W          = HIST_AW + 1;
	localparam int SYM_COUNT      = 256;
	localparam int SYM_W          = $clog2(SYM_COUNT);
	localparam int BYTE_W         = 8;
	localparam int CNT_W          = 8;
	localparam int LEN_W          = 13;
	localparam int PAGE_LEN_RST   = 4096;
	localparam int BYTES_PER_WORD = 4;
	localparam int LANE_W         = $clog2(BYTES_PER_WORD);
	localparam int WORD_W         = BYTES_PER_WORD * BYTE_W;
	localparam int OUT_CNT_W      = 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LIT,
		ST_COPY,
		ST_FLUSH
	} state_t;

	// sequencer to packer
	typedef struct packed {
		logic              push;
		logic [BYTE_W-1:0] data;
		logic              flush;
		logic              done;
	} pk_ctrl_t;

	// packer to sequencer
	typedef struct packed {
		logic push_ok;
		logic flush_ok;
	} pk_stat_t;

endpackage

// File: design/rtbd_if.sv
// Valid/ready channel interfaces for input items and packed result beats.
interface rtbd_item_if import rtbd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] literal;
	logic [CNT_W-1:0]  repeat_count;
	logic              new_page;

	modport source (output valid, output literal, output repeat_count, output new_page,
		input ready);
	modport sink (input valid, input literal, input repeat_count, input new_page,
		output ready);
endinterface

interface rtbd_result_if import rtbd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [WORD_W-1:0]    out_bytes;
	logic [OUT_CNT_W-1:0] out_count;
	logic                 out_last;
	logic                 page_done;

	modport source (output valid, output out_bytes, output out_count, output out_last,
		output page_done, input ready);
	modport sink (input valid, input out_bytes, input out_count, input out_last,
		input page_done, output ready);
endinterface

// File: design/rtbd_ram.sv
// Generic single write port, single read port RAM with registered read data.
module rtbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/rtbd_packer.sv
// Byte packer: gathers decoded bytes into four-byte words and holds the output beat register.
module rtbd_packer import rtbd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  pk_ctrl_t ctrl,
	output pk_stat_t stat,
	rtbd_result_if.source result
);

	logic [WORD_W-1:0]    word_q;
	logic [OUT_CNT_W-1:0] fill_q;
	logic                 word_full;
	logic                 take_push;
	logic                 take_flush;
	logic                 load;

	logic                 out_valid_q;
	logic [WORD_W-1:0]    out_bytes_q;
	logic [OUT_CNT_W-1:0] out_count_q;
	logic                 out_last_q;
	logic                 page_done_q;

	assign word_full     = (fill_q == OUT_CNT_W'(BYTES_PER_WORD));
	assign stat.push_ok  = !(word_full && out_valid_q && !result.ready);
	assign stat.flush_ok = !out_valid_q || result.ready;
	assign take_push     = ctrl.push && stat.push_ok;
	assign take_flush    = ctrl.flush && stat.flush_ok;
	// a full word leaves when the next byte shows it is not the last one, or on a flush
	assign load          = (take_push && word_full) || take_flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_flush) begin
				fill_q <= '0;
			end else if (take_push) begin
				fill_q <= word_full ? OUT_CNT_W'(1) : fill_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_push) begin
			if (word_full || fill_q == '0) begin
				word_q <= WORD_W'(ctrl.data);
			end else begin
				word_q[BYTE_W*fill_q[LANE_W-1:0] +: BYTE_W] <= ctrl.data;
			end
		end
		if (load) begin
			out_bytes_q <= word_q;
			out_count_q <= fill_q;
			out_last_q  <= take_flush;
			page_done_q <= take_flush && ctrl.done;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_bytes = out_bytes_q;
	assign result.out_count = out_count_q;
	assign result.out_last  = out_last_q;
	assign result.page_done = page_done_q;

endmodule

// File: design/rtime_block_decompressor_core.sv
// Top level: rtime page decompressor sequencer around the history RAM and last-position RAM.
// An item passes the literal state, the copy state while bytes remain, then the flush state;
// a new item is taken only in idle; an item on a full page is dropped in the literal state.
// The history RAM copies one byte per cycle while the packer takes each pushed byte.
// Reset: page_length returns to 4096, write position and all last positions clear at once;
// history contents stay undefined until written.
module rtime_block_decompressor_core import rtbd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             page_length_we,
	input  logic [LEN_W-1:0] page_length_wdata,
	rtbd_item_if.sink        item,
	rtbd_result_if.source    result
);

	state_t state_q, state_d;

	logic [LEN_W-1:0]     page_length_q;
	logic [POS_W-1:0]     eff_len;
	logic [POS_W-1:0]     wp_q;
	logic [POS_W-1:0]     wp_inc;
	logic                 full;
	logic                 accept;
	logic                 advance;

	logic [SYM_W-1:0]     sym_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [HIST_AW-1:0]   src_q;
	logic [SYM_COUNT-1:0] lp_valid_q;
	logic                 hit_q;
	logic [BYTE_W-1:0]    fwd_q;

	logic                 hist_we;
	logic [HIST_AW-1:0]   hist_waddr;
	logic [BYTE_W-1:0]    hist_wdata;
	logic [HIST_AW-1:0]   hist_raddr;
	logic [BYTE_W-1:0]    hist_rdata;
	logic [BYTE_W-1:0]    copy_byte;

	logic                 lp_we;
	logic [SYM_W-1:0]     lp_raddr;
	logic [POS_W-1:0]     lp_rdata;
	logic [POS_W-1:0]     lp_val;

	pk_ctrl_t             pk_ctrl;
	pk_stat_t             pk_stat;

	// Page length saturates at the history depth.
	always_comb begin
		if (32'(page_length_q) > 32'(HIST_DEPTH)) begin
			eff_len = POS_W'(HIST_DEPTH);
		end else begin
			eff_len = POS_W'(page_length_q);
		end
	end

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign wp_inc     = wp_q + 1'b1;
	assign full       = (wp_q >= eff_len);

	// A symbol with a cleared valid bit has not occurred in this page: copy from position 0.
	assign lp_val     = lp_valid_q[sym_q] ? lp_rdata : '0;

	// The read issued last cycle may target the byte written in that same cycle
	// (overlapping copy): take the written byte instead of the stale RAM word.
	assign copy_byte  = hit_q ? fwd_q : hist_rdata;
	assign hist_waddr = wp_q[HIST_AW-1:0];

	// Look up the symbol's last position on the accept beat, hold it while the literal waits.
	assign lp_raddr   = (state_q == ST_IDLE) ? item.literal : sym_q;

	rtbd_ram #(.WIDTH(BYTE_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	rtbd_ram #(.WIDTH(POS_W), .DEPTH(SYM_COUNT)) u_lp_ram (
		.clk   (clk),
		.we    (lp_we),
		.waddr (sym_q),
		.wdata (wp_inc),
		.raddr (lp_raddr),
		.rdata (lp_rdata)
	);

	rtbd_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (pk_ctrl),
		.stat   (pk_stat),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: literal, then one copied byte per cycle unless the packer stalls, then a final flush.
	always_comb begin
		state_d       = state_q;
		advance       = 1'b0;
		hist_we       = 1'b0;
		hist_wdata    = copy_byte;
		hist_raddr    = src_q;
		lp_we         = 1'b0;
		pk_ctrl       = '0;
		pk_ctrl.data  = copy_byte;
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					state_d = ST_LIT;
				end
			end
			ST_LIT: begin
				if (full) begin
					// page already complete: drop the item without a beat
					state_d = ST_IDLE;
				end else begin
					pk_ctrl.push = 1'b1;
					pk_ctrl.data = sym_q;
					hist_raddr   = lp_val[HIST_AW-1:0];
					if (pk_stat.push_ok) begin
						advance    = 1'b1;
						hist_we    = 1'b1;
						hist_wdata = sym_q;
						lp_we      = 1'b1;
						if (cnt_q == '0 || wp_inc >= eff_len) begin
							state_d = ST_FLUSH;
						end else begin
							state_d = ST_COPY;
						end
					end
				end
			end
			ST_COPY: begin
				pk_ctrl.push = 1'b1;
				if (pk_stat.push_ok) begin
					advance    = 1'b1;
					hist_we    = 1'b1;
					hist_raddr = src_q + 1'b1;
					if (cnt_q == CNT_W'(1) || wp_inc >= eff_len) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				pk_ctrl.flush = 1'b1;
				pk_ctrl.done  = full;
				if (pk_stat.flush_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state: page length register, write position, last-position valid bits, forwarding hit flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_length_q <= LEN_W'(PAGE_LEN_RST);
			wp_q          <= '0;
			lp_valid_q    <= '0;
			hit_q         <= 1'b0;
		end else begin
			if (page_length_we) begin
				page_length_q <= page_length_wdata;
			end
			if (accept && item.new_page) begin
				// new page: forget every symbol position and restart the page
				wp_q       <= '0;
				lp_valid_q <= '0;
			end else if (advance) begin
				wp_q <= wp_inc;
				if (state_q == ST_LIT) begin
					lp_valid_q[sym_q] <= 1'b1;
				end
			end
			hit_q <= hist_we && (hist_raddr == hist_waddr);
		end
	end

	// Item payload, copy source and forwarded byte.
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q <= item.literal;
			cnt_q <= item.repeat_count;
		end else if (advance) begin
			if (state_q == ST_LIT) begin
				src_q <= lp_val[HIST_AW-1:0];
			end else begin
				src_q <= src_q + 1'b1;
				cnt_q <= cnt_q - 1'b1;
			end
		end
		fwd_q <= hist_wdata;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.out_count != '0 &&
			result.out_count <= OUT_CNT_W'(BYTES_PER_WORD)))
		else $error("result beat with byte count out of range");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.page_done |-> result.out_last)
		else $error("page_done on a beat that is not the last of its item");

	a_copy_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COPY |-> cnt_q != '0)
		else $error("copy running with no bytes left");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= POS_W'(HIST_DEPTH))
		else $error("write position beyond history depth");

endmodule

// File: dv/rtbd_page_checker.sv
`timescale 1ns / 100ps
// Page decode checker: predicts the packed beats of every accepted item and compares them.
module rtbd_page_checker import rtbd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             page_length_we,
	input  logic [LEN_W-1:0] page_length_wdata,
	rtbd_item_if             item,
	rtbd_result_if           result,
	output int               mismatches,
	output int               beats_owed
);

	typedef struct packed {
		logic [WORD_W-1:0]    bytes;
		logic [OUT_CNT_W-1:0] count;
		logic                 last;
		logic                 done;
	} beat_t;

	logic [BYTE_W-1:0] page_mem [HIST_DEPTH];
	int                last_pos [SYM_COUNT];
	int                wr_pos;
	int                page_len;
	beat_t             decoded_beats [$];
	beat_t             seen_beat;
	beat_t             want_beat;

	// Decode one item into the page and queue the beats it produces.
	function automatic void decode_page_item(input logic [BYTE_W-1:0] lit,
		input logic [CNT_W-1:0] rep, input logic np);
		logic [BYTE_W-1:0] run [SYM_COUNT];
		int    lim;
		int    src;
		int    n;
		int    k;
		int    j;
		beat_t b;
		lim = (page_len > HIST_DEPTH) ? HIST_DEPTH : page_len;
		if (np) begin
			foreach (last_pos[s]) last_pos[s] = 0;
			wr_pos = 0;
		end
		if (wr_pos >= lim) return;
		page_mem[wr_pos] = lit;
		run[0] = lit;
		n = 1;
		src = last_pos[lit];
		wr_pos++;
		last_pos[lit] = wr_pos;
		// byte by byte, so an overlapping source replicates
		for (k = 0; k < int'(rep) && wr_pos < lim; k++) begin
			run[n] = page_mem[src];
			page_mem[wr_pos] = run[n];
			n++;
			src++;
			wr_pos++;
		end
		for (k = 0; k < n; k += BYTES_PER_WORD) begin
			b = '0;
			for (j = 0; j < BYTES_PER_WORD && k + j < n; j++)
				b.bytes[BYTE_W*j +: BYTE_W] = run[k+j];
			b.count = OUT_CNT_W'((n - k > BYTES_PER_WORD) ? BYTES_PER_WORD : n - k);
			b.last = (k + BYTES_PER_WORD >= n);
			b.done = b.last && (wr_pos >= lim);
			decoded_beats.insert(decoded_beats.size(), b);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (last_pos[s]) last_pos[s] = 0;
			wr_pos = 0;
			page_len = PAGE_LEN_RST;
			decoded_beats.delete();
		end else begin
			if (page_length_we)
				page_len = int'(page_length_wdata);
			if (item.valid && item.ready)
				decode_page_item(item.literal, item.repeat_count, item.new_page);
			if (result.valid && result.ready) begin
				seen_beat = '{result.out_bytes, result.out_count, result.out_last,
					result.page_done};
				if (decoded_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected beat bytes=%h count=%0d last=%b done=%b",
							$time, seen_beat.bytes, seen_beat.count, seen_beat.last,
							seen_beat.done);
				end else begin
					want_beat = decoded_beats.pop_front();
					if (seen_beat !== want_beat) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: beat differs, expected bytes=%h count=%0d ",
								"last=%b done=%b, got bytes=%h count=%0d last=%b done=%b"},
								$time, want_beat.bytes, want_beat.count, want_beat.last,
								want_beat.done, seen_beat.bytes, seen_beat.count,
								seen_beat.last, seen_beat.done);
					end
				end
			end
		end
		beats_owed = decoded_beats.size();
	end

endmodule

// File: dv/tb_rtime_block_decompressor_core.sv
`timescale 1ns / 100ps
// Testbench top: drives items, page length writes and result back-pressure, gives the verdict.
module tb_rtime_block_decompressor_core;
	import rtbd_pkg::*;

	localparam int RAND_ITEMS   = 470;
	localparam int DRAIN_CYCLES = 300;      // longest item has repeat count 255
	localparam int LONG_HOLD    = 1500;
	localparam int END_WAIT     = 200000;
	localparam int CYCLE_LIMIT  = 6000000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             page_length_we = 1'b0;
	logic [LEN_W-1:0] page_length_wdata = '0;

	rtbd_item_if   item_ch ();
	rtbd_result_if result_ch ();

	int mismatches;
	int beats_owed;
	int cycle_count = 0;
	int hold_len = 0;        // receiver hold-off request, consumed by the receiver process
	bit no_gaps = 1'b0;      // burst stretch: neither side idles
	int len_eff = HIST_DEPTH;
	int wp_est = 0;          // rough fill level, only to shape the stimulus
	int fed_items = 0;       // items offered, counted to size the random stretch

	rtime_block_decompressor_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.page_length_we   (page_length_we),
		.page_length_wdata(page_length_wdata),
		.item             (item_ch),
		.result           (result_ch)
	);

	rtbd_page_checker page_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.page_length_we   (page_length_we),
		.page_length_wdata(page_length_wdata),
		.item             (item_ch),
		.result           (result_ch),
		.mismatches       (mismatches),
		.beats_owed       (beats_owed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop on a hang.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rtime_block_decompressor_core: mismatch");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic int pick_rep();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return $urandom_range(0, 3);
		if (r < 75) return $urandom_range(4, 20);
		if (r < 90) return $urandom_range(21, 254);
		return 255;
	endfunction

	function automatic int pick_len();
		case ($urandom_range(0, 9))
			0: return $urandom_range(1, 16);
			1, 2, 3: return $urandom_range(17, 400);
			4, 5: return $urandom_range(401, 4095);
			6: return HIST_DEPTH;
			7: return $urandom_range(4097, 8191);
			8: return $urandom_range(0, 1);
			default: return $urandom_range(2, 64);
		endcase
	endfunction

	// Offer one item from a falling edge, hold it until accepted, then idle a while.
	task automatic offer(input logic [BYTE_W-1:0] lit, input logic [CNT_W-1:0] rep,
		input logic np);
		int gap;
		if (np)
			wp_est = 0;
		fed_items++;
		if (wp_est < len_eff)
			wp_est = (wp_est + 1 + int'(rep) > len_eff) ? len_eff : wp_est + 1 + int'(rep);
		item_ch.valid <= 1'b1;
		item_ch.literal <= lit;
		item_ch.repeat_count <= rep;
		item_ch.new_page <= np;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		@(negedge clk);
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			// scramble the payload while idle; the block must ignore it
			item_ch.valid <= 1'b0;
			item_ch.literal <= BYTE_W'($urandom);
			item_ch.repeat_count <= CNT_W'($urandom);
			item_ch.new_page <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drop valid, wait for every owed beat, then let any result-less item finish.
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (beats_owed != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_page_length(input int len);
		settle();
		page_length_we <= 1'b1;
		page_length_wdata <= LEN_W'(len);
		@(negedge clk);
		page_length_we <= 1'b0;
		len_eff = (len > HIST_DEPTH) ? HIST_DEPTH : len;
	endtask

	// Receiver: ready one cycle, then a random gap; a hold request overrides.
	initial begin
		int low_left;
		result_ch.ready = 1'b0;
		low_left = 0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				low_left = hold_len;
				hold_len = 0;
			end
			if (low_left > 0) begin
				result_ch.ready <= 1'b0;
				low_left--;
			end else begin
				result_ch.ready <= 1'b1;
				low_left = no_gaps ? 0 : pick_gap();
			end
		end
	end

	initial begin
		int                phase;
		int                asz;
		int                lit_base;
		int                page_items;
		int                k;
		logic              np;
		logic [BYTE_W-1:0] lit;
		item_ch.valid = 1'b0;
		item_ch.literal = '0;
		item_ch.repeat_count = '0;
		item_ch.new_page = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: default page length of 4096.
		offer(8'h00, 8'd0, 1'b1);       // lone literal, single byte beat
		offer(8'hFF, 8'd255, 1'b0);     // new literal copies from 0, overlaps, 64 beats
		offer(8'h00, 8'd5, 1'b0);       // seen literal: copy follows its last occurrence
		offer(8'hA5, 8'd1, 1'b0);
		offer(8'h5A, 8'd2, 1'b0);
		offer(8'hA5, 8'd3, 1'b0);
		offer(8'h5A, 8'd6, 1'b0);
		offer(8'hFF, 8'd7, 1'b0);
		offer(8'h00, 8'd4, 1'b1);       // restart the page mid-way

		// One-byte page: the literal alone fills it, the rest is dropped.
		set_page_length(1);
		offer(8'h3C, 8'd255, 1'b1);
		offer(8'hC3, 8'd9, 1'b0);       // full page: ignored
		offer(8'h3C, 8'd0, 1'b1);

		// Zero length: full at once, nothing comes out even after a new page.
		set_page_length(0);
		offer(8'h11, 8'd3, 1'b1);
		offer(8'h22, 8'd0, 1'b0);

		// Truncate an item at the page end.
		set_page_length(10);
		offer(8'h77, 8'd2, 1'b1);
		offer(8'h77, 8'd20, 1'b0);
		offer(8'h88, 8'd0, 1'b0);

		// Raise the length mid-page, then drop it under the fill level.
		set_page_length(40);
		offer(8'h99, 8'd0, 1'b0);
		set_page_length(8);
		offer(8'h99, 8'd3, 1'b0);

		// All-ones length saturates at the history depth.
		set_page_length(8191);
		offer(8'h42, 8'd255, 1'b1);
		offer(8'h42, 8'd255, 1'b0);
		offer(8'hBD, 8'd255, 1'b0);
		offer(8'h42, 8'd255, 1'b0);

		// Random pages: mostly well-formed with a small alphabet so literals recur.
		fed_items = 0;
		phase = 0;
		while (fed_items < RAND_ITEMS) begin
			if (phase == 2) begin
				// hold the receiver off and keep offering full-length items
				set_page_length(HIST_DEPTH);
				no_gaps = 1'b1;
				hold_len = LONG_HOLD;
				for (k = 0; k < 16; k++)
					offer(BYTE_W'($urandom), 8'd255, k == 0);
			end else begin
				set_page_length(pick_len());
				no_gaps = ($urandom_range(0, 4) == 0);
				repeat ($urandom_range(1, 3)) begin
					case ($urandom_range(0, 4))
						0: asz = 1;
						1: asz = 2;
						2: asz = 4;
						3: asz = 16;
						default: asz = 256;
					endcase
					lit_base = $urandom_range(0, 255);
					page_items = 0;
					np = 1'b1;
					do begin
						lit = BYTE_W'(lit_base + $urandom_range(0, asz - 1));
						offer(lit, CNT_W'(pick_rep()), np);
						page_items++;
						// broken sequence now and then: a restart mid-page
						np = ($urandom_range(0, 39) == 0);
					end while (wp_est < len_eff && page_items < 60 && fed_items < RAND_ITEMS);
					// a few trailing items, usually on a full page
					repeat ($urandom_range(0, 2))
						offer(BYTE_W'($urandom), CNT_W'(pick_rep()), 1'b0);
				end
			end
			phase++;
		end

		// Drain: wait for the owed beats, with a limit, then for stragglers.
		item_ch.valid <= 1'b0;
		for (k = 0; k < END_WAIT && beats_owed != 0; k++)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && beats_owed == 0) begin
			$display("rtime_block_decompressor_core: match");
		end else begin
			$display("rtime_block_decompressor_core: mismatch");
		end
		$finish;
	end

endmodule
